[rtl/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg: shared constants and types of the range bitmap store
// Field widths, configuration layout, default geometry and request codes.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int MAX_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 64;

  localparam int REQ_W = 2;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;

  localparam int BITS_RESET = 4096;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic REG_BITS_IN_USE = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_RANGE = 2'd0,
    REQ_CLR_BIT   = 2'd1,
    REQ_TEST_BIT  = 2'd2,
    REQ_CLR_ALL   = 2'd3
  } req_t;

endpackage

[rtl/rbs_req_if.sv]
// ----------------------------------------------------------------------------
// rbs_req_if: request channel of the range bitmap store
// Valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface rbs_req_if;

  logic                       valid;
  logic                       ready;
  logic [rbs_pkg::REQ_W-1:0]  req_type;
  logic [rbs_pkg::IDX_W-1:0]  first_bit;
  logic [rbs_pkg::IDX_W-1:0]  last_bit;

  modport source (output valid, req_type, first_bit, last_bit, input ready);
  modport sink   (input valid, req_type, first_bit, last_bit, output ready);

endinterface

[rtl/rbs_rsp_if.sv]
// ----------------------------------------------------------------------------
// rbs_rsp_if: result channel of the range bitmap store
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface rbs_rsp_if;

  logic valid;
  logic ready;
  logic bit_value;
  logic index_bad;
  logic range_fixed;
  logic all_clear;

  modport source (output valid, bit_value, index_bad, range_fixed, all_clear, input ready);
  modport sink   (input valid, bit_value, index_bad, range_fixed, all_clear, output ready);

endinterface

[rtl/range_bitmap_store_unit.sv]
// ----------------------------------------------------------------------------
// range_bitmap_store_unit: word-organised bitmap with range set
// Set range, clear bit, test bit and clear all over a bitmap held in one
// synchronous word memory, with a nonzero flag per word.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------
//  in_ch    | sink      | req_type, first_bit, last_bit
//  out_ch   | source    | bit_value, index_bad, range_fixed, all_clear
//  apb      | slave     | bits_in_use at byte address 0
//
//  Each item walks every word of the memory once: a read of each word,
//  the write-back of the last word, then the load of the result register.
//  The walk through the word memory, with one read and one write port,
//  sets the time from accept to result. Reset clears the per-word nonzero
//  flags directly, with no clearing pass. A new item is taken while the
//  previous result waits; a stalled result holds the finished walk until
//  it is taken.
// ----------------------------------------------------------------------------
module range_bitmap_store_unit #(
  parameter int MAX_BITS  = rbs_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = rbs_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rbs_req_if.sink                         in_ch,
  rbs_rsp_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rbs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int PW_RAW     = $clog2(WORD_COUNT * WORD_BITS + WORD_BITS + 1);
  localparam int PW         = (PW_RAW > rbs_pkg::CNT_W) ? PW_RAW : rbs_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [rbs_pkg::CNT_W-1:0]  bits_in_use_r;

  logic [WORD_BITS-1:0]       bit_words [WORD_COUNT];
  logic [WORD_BITS-1:0]       rdata_r;
  logic [WORD_COUNT-1:0]      nz_r, nz_nxt;

  logic [WA_W-1:0]            a_r, a_nxt;
  logic [PW-1:0]              base_r, base_nxt;
  logic                       s_vld_r, s_vld_nxt;
  logic [WA_W-1:0]            s_addr_r, s_addr_nxt;
  logic [PW-1:0]              s_base_r, s_base_nxt;

  rbs_pkg::req_t              op_r, op_nxt;
  logic [PW-1:0]              first_r, first_nxt;
  logic [PW-1:0]              last_r, last_nxt;
  logic [PW-1:0]              n_r, n_nxt;
  logic                       fixed_r, fixed_nxt;
  logic                       bad_r, bad_nxt;
  logic                       bitv_r, bitv_nxt;
  logic                       acc_r, acc_nxt;

  logic                       out_vld_r, out_vld_nxt;
  logic                       out_bit_r, out_bit_nxt;
  logic                       out_bad_r, out_bad_nxt;
  logic                       out_fix_r, out_fix_nxt;
  logic                       out_clr_r, out_clr_nxt;

  logic                       cfg_wr;
  logic [PW-1:0]              n_raw, n_eff, n_m1, f_ext, l_ext, f_cl, l_cl;
  logic                       rev;

  logic [PW-1:0]              wend;
  logic [WORD_BITS-1:0]       word_old, word_new, span_m, pt_m;
  logic [OFF_W-1:0]           lo_off, hi_off, pt_off;
  logic                       pt_hit, word_use, wr, tbit;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rbs_pkg::REG_BITS_IN_USE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rbs_pkg::REG_BITS_IN_USE)
                ? rbs_pkg::CFG_DATA_W'(bits_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= rbs_pkg::CNT_W'(rbs_pkg::BITS_RESET);
    end else if (cfg_wr) begin
      bits_in_use_r <= pwdata[rbs_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    n_raw = PW'(bits_in_use_r);
    if (n_raw == '0) begin
      n_eff = PW'(1);
    end else if (n_raw > PW'(MAX_BITS)) begin
      n_eff = PW'(MAX_BITS);
    end else begin
      n_eff = n_raw;
    end
    n_m1  = n_eff - PW'(1);
    f_ext = PW'(in_ch.first_bit);
    l_ext = PW'(in_ch.last_bit);
    f_cl  = (f_ext >= n_eff) ? n_m1 : f_ext;
    l_cl  = (l_ext >= n_eff) ? n_m1 : l_ext;
    rev   = f_cl > l_cl;
  end

  always_ff @(posedge clk) begin
    if (s_vld_r && wr) begin
      bit_words[s_addr_r] <= word_new;
    end
    rdata_r <= bit_words[a_r];
  end

  always_comb begin
    wend     = s_base_r + PW'(WORD_BITS - 1);
    word_old = nz_r[s_addr_r] ? rdata_r : '0;
    lo_off   = (first_r > s_base_r) ? OFF_W'(first_r - s_base_r) : '0;
    hi_off   = (last_r < wend) ? OFF_W'(last_r - s_base_r) : OFF_W'(WORD_BITS - 1);
    pt_off   = OFF_W'(first_r - s_base_r);
    pt_hit   = (s_base_r <= first_r) && (first_r <= wend) && !bad_r;
    word_use = s_base_r < n_r;
    for (int j = 0; j < WORD_BITS; j++) begin
      span_m[j] = (OFF_W'(j) >= lo_off) && (OFF_W'(j) <= hi_off);
      pt_m[j]   = OFF_W'(j) == pt_off;
    end
    word_new = word_old;
    wr       = 1'b0;
    tbit     = 1'b0;
    unique case (op_r)
      rbs_pkg::REQ_SET_RANGE: begin
        wr = (s_base_r <= last_r) && (wend >= first_r);
        if (wr) word_new = word_old | span_m;
      end
      rbs_pkg::REQ_CLR_BIT: begin
        wr = pt_hit;
        if (wr) word_new = word_old & ~pt_m;
      end
      rbs_pkg::REQ_TEST_BIT: begin
        tbit = pt_hit && |(word_old & pt_m);
      end
      rbs_pkg::REQ_CLR_ALL: begin
        wr = word_use;
        if (wr) word_new = '0;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    nz_nxt = nz_r;
    if (s_vld_r && wr) nz_nxt[s_addr_r] = |word_new;
  end

  always_comb begin
    state_nxt   = state_r;
    a_nxt       = a_r;
    base_nxt    = base_r;
    s_vld_nxt   = 1'b0;
    s_addr_nxt  = s_addr_r;
    s_base_nxt  = s_base_r;
    op_nxt      = op_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    n_nxt       = n_r;
    fixed_nxt   = fixed_r;
    bad_nxt     = bad_r;
    bitv_nxt    = bitv_r;
    acc_nxt     = acc_r;
    out_vld_nxt = out_vld_r;
    out_bit_nxt = out_bit_r;
    out_bad_nxt = out_bad_r;
    out_fix_nxt = out_fix_r;
    out_clr_nxt = out_clr_r;

    if (s_vld_r) begin
      bitv_nxt = bitv_r | tbit;
      acc_nxt  = acc_r | (word_use && |word_new);
    end
    if (out_vld_r && out_ch.ready) out_vld_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = rbs_pkg::req_t'(in_ch.req_type);
          n_nxt     = n_eff;
          a_nxt     = '0;
          base_nxt  = '0;
          bitv_nxt  = 1'b0;
          acc_nxt   = 1'b0;
          fixed_nxt = 1'b0;
          bad_nxt   = 1'b0;
          if (rbs_pkg::req_t'(in_ch.req_type) == rbs_pkg::REQ_SET_RANGE) begin
            first_nxt = rev ? l_cl : f_cl;
            last_nxt  = l_cl;
            fixed_nxt = rev;
          end else begin
            first_nxt = f_ext;
            last_nxt  = l_cl;
            bad_nxt   = (rbs_pkg::req_t'(in_ch.req_type) != rbs_pkg::REQ_CLR_ALL)
                     && (f_ext >= n_eff);
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        s_vld_nxt  = 1'b1;
        s_addr_nxt = a_r;
        s_base_nxt = base_r;
        a_nxt      = a_r + WA_W'(1);
        base_nxt   = base_r + PW'(WORD_BITS);
        if (a_r == WA_W'(WORD_COUNT - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!s_vld_r && (!out_vld_r || out_ch.ready)) begin
          out_vld_nxt = 1'b1;
          out_bit_nxt = bitv_r;
          out_bad_nxt = bad_r;
          out_fix_nxt = fixed_r;
          out_clr_nxt = !acc_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      s_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      nz_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      s_vld_r   <= s_vld_nxt;
      out_vld_r <= out_vld_nxt;
      nz_r      <= nz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    base_r    <= base_nxt;
    s_addr_r  <= s_addr_nxt;
    s_base_r  <= s_base_nxt;
    op_r      <= op_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    n_r       <= n_nxt;
    fixed_r   <= fixed_nxt;
    bad_r     <= bad_nxt;
    bitv_r    <= bitv_nxt;
    acc_r     <= acc_nxt;
    out_bit_r <= out_bit_nxt;
    out_bad_r <= out_bad_nxt;
    out_fix_r <= out_fix_nxt;
    out_clr_r <= out_clr_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.bit_value   = out_bit_r;
  assign out_ch.index_bad   = out_bad_r;
  assign out_ch.range_fixed = out_fix_r;
  assign out_ch.all_clear   = out_clr_r;

endmodule

[rtl/rbs_checker.sv]
// ----------------------------------------------------------------------------
// rbs_checker: port-level checks of the range bitmap store
// Result consistency and hold behaviour seen at the top level's ports.
// ----------------------------------------------------------------------------
module rbs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic bit_value,
  input logic index_bad,
  input logic range_fixed,
  input logic all_clear
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({bit_value, index_bad, range_fixed, all_clear}))
    else $error("result item changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(index_bad && range_fixed))
    else $error("index_bad and range_fixed on one item");

  a_bit_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bit_value |-> !index_bad && !all_clear)
    else $error("set test bit with bad index or empty map");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken during a walk");

endmodule

bind range_bitmap_store_unit rbs_checker u_rbs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .bit_value   (out_ch.bit_value),
  .index_bad   (out_ch.index_bad),
  .range_fixed (out_ch.range_fixed),
  .all_clear   (out_ch.all_clear)
);
